// ===== hdl/fcpa_pkg.sv =====
`default_nettype none
package fcpa_pkg;

    // Result status codes
    localparam logic [2:0] STAT_OK           = 3'd0;
    localparam logic [2:0] STAT_TOO_LARGE    = 3'd1;
    localparam logic [2:0] STAT_NONE_FREE    = 3'd2;
    localparam logic [2:0] STAT_MISALIGNED   = 3'd3;
    localparam logic [2:0] STAT_OUT_OF_RANGE = 3'd4;
    localparam logic [2:0] STAT_NOT_IN_USE   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_CHUNK_SIZE   = 2'd1;
    localparam logic [1:0] CFG_CHUNK_COUNT  = 2'd2;

    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int REQ_W   = 33;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_TEST,
        S_DONE
    } fcpa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted request
        logic scan;      // check one chunk of the allocate scan
        logic prep;      // range check and offset for a free
        logic div;       // one quotient bit of offset / chunk_size
        logic test;      // final free checks and bit clear
        logic out_load;  // move the result into the output register
    } fcpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;   // allocate decided this cycle
        logic prep_fail;  // free rejected before division
        logic div_last;   // last quotient bit this cycle
        logic out_free;   // output register can take a result
    } fcpa_stat_t;

endpackage
`default_nettype wire

// ===== hdl/fcpa_ctrl.sv =====
`default_nettype none
module fcpa_ctrl
    import fcpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tuser,
    output logic            s_tready,
    input  fcpa_stat_t      stat,
    output fcpa_cmd_t       cmd
);

    fcpa_state_t state_reg;
    fcpa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = s_tuser ? S_PREP : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_PREP:
            begin
                state_next = stat.prep_fail ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
            end
            S_TEST:
            begin
                cmd.test = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/fcpa_datapath.sv =====
`default_nettype none
module fcpa_datapath
    import fcpa_pkg::*;
#(
    parameter int MAX_CHUNKS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    input  wire logic [REQ_W-1:0]     in_size,
    input  wire logic [ADDR_W-1:0]    in_address,
    input  fcpa_cmd_t                 cmd,
    output fcpa_stat_t                stat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                out_status,
    output logic [ADDR_W-1:0]         out_address,
    output logic [INDEX_W-1:0]        out_index
);

    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int BIT_W = $clog2(ADDR_W);

    // Configuration
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  csize_reg;
    logic [COUNT_W-1:0] ccount_reg;

    // Chunk state
    logic [MAX_CHUNKS-1:0] used_reg;

    // Request and working registers
    logic [REQ_W-1:0]   size_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic [ADDR_W-1:0]  acc_reg;
    logic [ADDR_W-1:0]  quo_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic [BIT_W-1:0]   bit_reg;

    logic [2:0]         res_status_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [INDEX_W-1:0] res_idx_reg;

    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [INDEX_W-1:0] out_idx_reg;

    logic [CNT_W-1:0]   live;
    logic [IDX_W-1:0]   scan_idx;
    logic [IDX_W-1:0]   quo_idx;
    logic               too_large;
    logic               scan_past;
    logic               below_base;
    logic [SIZE_W:0]    shifted;
    logic [SIZE_W+1:0]  diff;
    logic               quo_past;

    assign live = (32'(ccount_reg) > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS) : CNT_W'(ccount_reg);

    assign scan_idx   = scan_reg[IDX_W-1:0];
    assign quo_idx    = quo_reg[IDX_W-1:0];
    assign too_large  = size_reg > {1'b0, csize_reg};
    assign scan_past  = scan_reg >= live;
    assign below_base = addr_reg < base_reg;
    assign shifted    = {rem_reg, quo_reg[ADDR_W-1]};
    assign diff       = {1'b0, shifted} - (SIZE_W + 2)'(csize_reg);
    assign quo_past   = quo_reg >= ADDR_W'(live);

    assign stat.scan_end  = too_large || scan_past || !used_reg[scan_idx];
    assign stat.prep_fail = below_base || (csize_reg == '0);
    assign stat.div_last  = (bit_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Configuration, chunk bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            csize_reg     <= SIZE_W'(4096);
            ccount_reg    <= COUNT_W'(64);
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BASE_ADDRESS: base_reg   <= cfg_data;
                    CFG_CHUNK_SIZE:   csize_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_CHUNK_COUNT:  ccount_reg <= cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.scan && !too_large && !scan_past && !used_reg[scan_idx])
            begin
                used_reg[scan_idx] <= 1'b1;
            end
            if (cmd.test && (rem_reg == '0) && !quo_past && used_reg[quo_idx])
            begin
                used_reg[quo_idx] <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request, scan, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg <= in_size;
            addr_reg <= in_address;
            scan_reg <= '0;
            acc_reg  <= base_reg;
        end

        if (cmd.scan)
        begin
            if (too_large)
            begin
                res_status_reg <= STAT_TOO_LARGE;
                res_addr_reg   <= '0;
                res_idx_reg    <= '0;
            end
            else if (scan_past)
            begin
                res_status_reg <= STAT_NONE_FREE;
                res_addr_reg   <= '0;
                res_idx_reg    <= '0;
            end
            else if (!used_reg[scan_idx])
            begin
                res_status_reg <= STAT_OK;
                res_addr_reg   <= acc_reg;
                res_idx_reg    <= INDEX_W'(scan_reg);
            end
            else
            begin
                // advance to the next chunk and its address
                scan_reg <= scan_reg + CNT_W'(1);
                acc_reg  <= acc_reg + ADDR_W'(csize_reg);
            end
        end

        if (cmd.prep)
        begin
            quo_reg <= addr_reg - base_reg;
            rem_reg <= '0;
            bit_reg <= BIT_W'(ADDR_W - 1);
            res_status_reg <= STAT_OUT_OF_RANGE;
            res_addr_reg   <= '0;
            res_idx_reg    <= '0;
        end

        // Restoring division: the offset shifts out of quo_reg as quotient bits shift in
        if (cmd.div)
        begin
            bit_reg <= bit_reg - BIT_W'(1);
            if (!diff[SIZE_W+1])
            begin
                rem_reg <= diff[SIZE_W-1:0];
                quo_reg <= {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[SIZE_W-1:0];
                quo_reg <= {quo_reg[ADDR_W-2:0], 1'b0};
            end
        end

        if (cmd.test)
        begin
            res_addr_reg <= '0;
            res_idx_reg  <= '0;
            if (rem_reg != '0)
            begin
                res_status_reg <= STAT_MISALIGNED;
            end
            else if (quo_past)
            begin
                res_status_reg <= STAT_OUT_OF_RANGE;
            end
            else if (!used_reg[quo_idx])
            begin
                res_status_reg <= STAT_NOT_IN_USE;
            end
            else
            begin
                res_status_reg <= STAT_OK;
                res_idx_reg    <= INDEX_W'(quo_idx);
            end
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_idx_reg    <= res_idx_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_address = out_addr_reg;
    assign out_index   = out_idx_reg;

endmodule
`default_nettype wire

// ===== hdl/fixed_chunk_pool_allocator.sv =====
// Chunk pool allocator with one used flag per chunk.
// Input stream (s_*): one request per transfer. s_tuser is the command
// (0 allocate, 1 free); s_tdata carries the request size and the address to free.
// Output stream (m_*): one result per request, in order. m_tuser is the status,
// m_tdata carries the allocated address and the chunk index.
// Configuration channel (cfg_*): index 0 base address, 1 chunk size,
// 2 chunk count; always ready, write only while no request is in flight.
// Sequencing: one request at a time. An allocate scans the used flags
// one chunk per cycle until it finds a free chunk or passes the chunk
// count; a request larger than the chunk size is rejected by the scan. A free
// runs a one-bit-per-cycle divider over the 48-bit offset, then a final
// test state; it skips the divider when the address is below the base or
// the chunk size is zero. s_tready is high only between requests, so the
// next request is taken in the cycle after the result is loaded.
// The result sits in an output register; a new request is taken while it
// waits. When the receiver stalls, the next result holds inside the block until
// the output register drains.
// Reset clears all used flags (every chunk free) and loads the register
// defaults: base 0, chunk size 4096, chunk count 64.
`default_nettype none
module fixed_chunk_pool_allocator
    import fcpa_pkg::*;
#(
    parameter int MAX_CHUNKS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // [32:0] request_size, [80:33] free_address
    input  wire logic        s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [47:0] chunk_address, [53:48] chunk_index
    output logic [2:0]       m_tuser,   // [2:0] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    fcpa_cmd_t          cmd;
    fcpa_stat_t         stat;
    logic [2:0]         out_status;
    logic [ADDR_W-1:0]  out_address;
    logic [INDEX_W-1:0] out_index;

    assign cfg_ready = 1'b1;

    fcpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcpa_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_size     (s_tdata[REQ_W-1:0]),
        .in_address  (s_tdata[REQ_W+ADDR_W-1:REQ_W]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_address (out_address),
        .out_index   (out_index)
    );

    assign m_tdata = {2'b00, out_index, out_address};
    assign m_tuser = out_status;

    // One request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !m_tvalid || m_tready)
        else $error("output register overwritten");

    // Only a successful allocate returns an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata[47:0] == '0) && (m_tdata[53:48] == '0))
        else $error("error result with nonzero address or index");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= STAT_NOT_IN_USE)
        else $error("undefined status code");

endmodule
`default_nettype wire
